FILE: design/srect_pkg.sv
package srect_pkg;

   // rectangle fields are whole pixels, fixed width
   localparam int RECT_WIDTH = 12;

   // default coordinate format: signed, 12 integer and 4 fraction bits
   localparam int COORD_FRAC_DEFAULT = 4;
   localparam int COORD_INT_DEFAULT  = 12;

endpackage

FILE: design/segment_rect_intersect.sv
// Segment versus axis-aligned rectangle overlap test. Each transaction carries one segment
// (signed fixed-point endpoints) and one rectangle (whole pixels, edges included) and gives
// exactly one rsp_hit, shown with rsp_valid for a single cycle. A new transaction may start
// in every cycle; busy stays low. The receiver cannot stall the block, and none is needed,
// because results leave in the order they entered. The pipeline runs through six stages
// that clip x, form the offsets and multiply, then the restoring divider, one quotient bit
// per stage for each of the two interpolated y values, and then two stages that place the
// y values and compare them with the rectangle.
module segment_rect_intersect #(
   parameter int COORD_FRAC_BITS = srect_pkg::COORD_FRAC_DEFAULT,
   parameter int COORD_INT_BITS  = srect_pkg::COORD_INT_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               start,
   output logic                                               busy,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   req_seg_x1,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   req_seg_y1,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   req_seg_x2,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   req_seg_y2,
   input  logic [srect_pkg::RECT_WIDTH-1:0]                   req_rect_x,
   input  logic [srect_pkg::RECT_WIDTH-1:0]                   req_rect_y,
   input  logic [srect_pkg::RECT_WIDTH-1:0]                   req_rect_w,
   input  logic [srect_pkg::RECT_WIDTH-1:0]                   req_rect_h,
   output logic                                               rsp_valid,
   output logic                                               rsp_hit
);
   import srect_pkg::*;

   localparam int CW      = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int RB      = RECT_WIDTH + 1 + COORD_FRAC_BITS;
   localparam int EW      = (CW > RB) ? CW : RB;
   localparam int WW      = EW + 3;
   localparam int NW      = 2 * CW;
   localparam int LATENCY = CW + 8;

   logic accept;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 1: input register
   logic                   s1_valid_ff;
   logic signed [CW-1:0]   s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   logic [RECT_WIDTH-1:0]  s1_rx_ff, s1_ry_ff, s1_rw_ff, s1_rh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_x1_ff <= req_seg_x1;
      s1_y1_ff <= req_seg_y1;
      s1_x2_ff <= req_seg_x2;
      s1_y2_ff <= req_seg_y2;
      s1_rx_ff <= req_rect_x;
      s1_ry_ff <= req_rect_y;
      s1_rw_ff <= req_rect_w;
      s1_rh_ff <= req_rect_h;
   end

   // stage 2: segment x order and rectangle bounds in coordinate units
   logic signed [WW-1:0]   x1_wide, x2_wide;
   logic signed [WW-1:0]   s2_lo_in, s2_hi_in;
   logic signed [WW-1:0]   s2_rminx_in, s2_rmaxx_in, s2_rminy_in, s2_rmaxy_in;
   logic                   s2_valid_ff;
   logic signed [WW-1:0]   s2_lo_ff, s2_hi_ff;
   logic signed [WW-1:0]   s2_rminx_ff, s2_rmaxx_ff, s2_rminy_ff, s2_rmaxy_ff;
   logic signed [CW-1:0]   s2_x1_ff, s2_y1_ff, s2_x2_ff, s2_y2_ff;

   assign x1_wide     = WW'(s1_x1_ff);
   assign x2_wide     = WW'(s1_x2_ff);
   assign s2_lo_in    = (x1_wide < x2_wide) ? x1_wide : x2_wide;
   assign s2_hi_in    = (x1_wide < x2_wide) ? x2_wide : x1_wide;
   assign s2_rminx_in = WW'(s1_rx_ff) << COORD_FRAC_BITS;
   assign s2_rmaxx_in = (WW'(s1_rx_ff) + WW'(s1_rw_ff)) << COORD_FRAC_BITS;
   assign s2_rminy_in = WW'(s1_ry_ff) << COORD_FRAC_BITS;
   assign s2_rmaxy_in = (WW'(s1_ry_ff) + WW'(s1_rh_ff)) << COORD_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_lo_ff    <= s2_lo_in;
      s2_hi_ff    <= s2_hi_in;
      s2_rminx_ff <= s2_rminx_in;
      s2_rmaxx_ff <= s2_rmaxx_in;
      s2_rminy_ff <= s2_rminy_in;
      s2_rmaxy_ff <= s2_rmaxy_in;
      s2_x1_ff    <= s1_x1_ff;
      s2_y1_ff    <= s1_y1_ff;
      s2_x2_ff    <= s1_x2_ff;
      s2_y2_ff    <= s1_y2_ff;
   end

   // stage 3: clip x to the rectangle, deltas, empty and vertical flags
   logic signed [WW-1:0]   s3_lo_in, s3_hi_in;
   logic                   s3_empty_in, s3_vert_in;
   logic signed [CW:0]     s3_dx_in, s3_dy_in;
   logic                   s3_valid_ff, s3_empty_ff, s3_vert_ff;
   logic signed [WW-1:0]   s3_lo_ff, s3_hi_ff, s3_rminy_ff, s3_rmaxy_ff;
   logic signed [CW:0]     s3_dx_ff, s3_dy_ff;
   logic signed [CW-1:0]   s3_x1_ff, s3_y1_ff, s3_y2_ff;

   assign s3_lo_in    = (s2_lo_ff < s2_rminx_ff) ? s2_rminx_ff : s2_lo_ff;
   assign s3_hi_in    = (s2_hi_ff > s2_rmaxx_ff) ? s2_rmaxx_ff : s2_hi_ff;
   // clipped span is empty when the segment lies wholly left or right of the box
   assign s3_empty_in = (s2_lo_ff > s2_rmaxx_ff) || (s2_hi_ff < s2_rminx_ff);
   assign s3_vert_in  = (s2_x1_ff == s2_x2_ff);
   assign s3_dx_in    = (CW+1)'(s2_x2_ff) - (CW+1)'(s2_x1_ff);
   assign s3_dy_in    = (CW+1)'(s2_y2_ff) - (CW+1)'(s2_y1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_lo_ff    <= s3_lo_in;
      s3_hi_ff    <= s3_hi_in;
      s3_empty_ff <= s3_empty_in;
      s3_vert_ff  <= s3_vert_in;
      s3_dx_ff    <= s3_dx_in;
      s3_dy_ff    <= s3_dy_in;
      s3_rminy_ff <= s2_rminy_ff;
      s3_rmaxy_ff <= s2_rmaxy_ff;
      s3_x1_ff    <= s2_x1_ff;
      s3_y1_ff    <= s2_y1_ff;
      s3_y2_ff    <= s2_y2_ff;
   end

   // stage 4: offsets of the clipped ends from x1, delta magnitudes
   logic signed [WW-1:0]   s4_off_lo_in, s4_off_hi_in;
   logic signed [CW:0]     dx_abs, dy_abs;
   logic                   s4_valid_ff, s4_empty_ff, s4_vert_ff, s4_dxneg_ff, s4_dyneg_ff;
   logic signed [WW-1:0]   s4_off_lo_ff, s4_off_hi_ff, s4_rminy_ff, s4_rmaxy_ff;
   logic [CW-1:0]          s4_dmag_ff, s4_dymag_ff;
   logic signed [CW-1:0]   s4_y1_ff, s4_y2_ff;

   assign s4_off_lo_in = s3_lo_ff - WW'(s3_x1_ff);
   assign s4_off_hi_in = s3_hi_ff - WW'(s3_x1_ff);
   assign dx_abs       = s3_dx_ff[CW] ? -s3_dx_ff : s3_dx_ff;
   assign dy_abs       = s3_dy_ff[CW] ? -s3_dy_ff : s3_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_off_lo_ff <= s4_off_lo_in;
      s4_off_hi_ff <= s4_off_hi_in;
      s4_dmag_ff   <= dx_abs[CW-1:0];
      s4_dymag_ff  <= dy_abs[CW-1:0];
      s4_dxneg_ff  <= s3_dx_ff[CW];
      s4_dyneg_ff  <= s3_dy_ff[CW];
      s4_empty_ff  <= s3_empty_ff;
      s4_vert_ff   <= s3_vert_ff;
      s4_rminy_ff  <= s3_rminy_ff;
      s4_rmaxy_ff  <= s3_rmaxy_ff;
      s4_y1_ff     <= s3_y1_ff;
      s4_y2_ff     <= s3_y2_ff;
   end

   // stage 5: offset magnitudes and quotient signs
   logic signed [WW-1:0]   off_lo_abs, off_hi_abs;
   logic                   s5_neg_lo_in, s5_neg_hi_in;
   logic                   s5_valid_ff, s5_empty_ff, s5_vert_ff, s5_neg_lo_ff, s5_neg_hi_ff;
   logic [CW-1:0]          s5_mag_lo_ff, s5_mag_hi_ff, s5_dmag_ff, s5_dymag_ff;
   logic signed [WW-1:0]   s5_rminy_ff, s5_rmaxy_ff;
   logic signed [CW-1:0]   s5_y1_ff, s5_y2_ff;

   assign off_lo_abs   = s4_off_lo_ff[WW-1] ? -s4_off_lo_ff : s4_off_lo_ff;
   assign off_hi_abs   = s4_off_hi_ff[WW-1] ? -s4_off_hi_ff : s4_off_hi_ff;
   assign s5_neg_lo_in = s4_off_lo_ff[WW-1] ^ s4_dxneg_ff ^ s4_dyneg_ff;
   assign s5_neg_hi_in = s4_off_hi_ff[WW-1] ^ s4_dxneg_ff ^ s4_dyneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_mag_lo_ff <= off_lo_abs[CW-1:0];
      s5_mag_hi_ff <= off_hi_abs[CW-1:0];
      s5_neg_lo_ff <= s5_neg_lo_in;
      s5_neg_hi_ff <= s5_neg_hi_in;
      s5_dmag_ff   <= s4_dmag_ff;
      s5_dymag_ff  <= s4_dymag_ff;
      s5_empty_ff  <= s4_empty_ff;
      s5_vert_ff   <= s4_vert_ff;
      s5_rminy_ff  <= s4_rminy_ff;
      s5_rmaxy_ff  <= s4_rmaxy_ff;
      s5_y1_ff     <= s4_y1_ff;
      s5_y2_ff     <= s4_y2_ff;
   end

   // divider pipeline, entry 0 is loaded by the multiply stage
   logic                   dv_valid_ff [0:CW];
   logic [NW-1:0]          rem_lo_ff   [0:CW];
   logic [NW-1:0]          rem_hi_ff   [0:CW];
   logic [CW-1:0]          quo_lo_ff   [0:CW];
   logic [CW-1:0]          quo_hi_ff   [0:CW];
   logic [CW-1:0]          dv_d_ff     [0:CW];
   logic                   dv_neg_lo_ff[0:CW];
   logic                   dv_neg_hi_ff[0:CW];
   logic                   dv_empty_ff [0:CW];
   logic                   dv_vert_ff  [0:CW];
   logic signed [WW-1:0]   dv_rminy_ff [0:CW];
   logic signed [WW-1:0]   dv_rmaxy_ff [0:CW];
   logic signed [CW-1:0]   dv_y1_ff    [0:CW];
   logic signed [CW-1:0]   dv_y2_ff    [0:CW];

   // stage 6: products |dy| * |x - x1| for both clipped ends
   logic [NW-1:0]          prod_lo_in, prod_hi_in;

   assign prod_lo_in = NW'(s5_dymag_ff) * NW'(s5_mag_lo_ff);
   assign prod_hi_in = NW'(s5_dymag_ff) * NW'(s5_mag_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= s5_valid_ff;
      end
      rem_lo_ff[0]    <= prod_lo_in;
      rem_hi_ff[0]    <= prod_hi_in;
      quo_lo_ff[0]    <= '0;
      quo_hi_ff[0]    <= '0;
      dv_d_ff[0]      <= s5_dmag_ff;
      dv_neg_lo_ff[0] <= s5_neg_lo_ff;
      dv_neg_hi_ff[0] <= s5_neg_hi_ff;
      dv_empty_ff[0]  <= s5_empty_ff;
      dv_vert_ff[0]   <= s5_vert_ff;
      dv_rminy_ff[0]  <= s5_rminy_ff;
      dv_rmaxy_ff[0]  <= s5_rmaxy_ff;
      dv_y1_ff[0]     <= s5_y1_ff;
      dv_y2_ff[0]     <= s5_y2_ff;
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar k = 0; k < CW; k++) begin : g_div
      localparam int SH = CW - 1 - k;
      logic [NW:0]   diff_lo, diff_hi;
      logic [NW-1:0] rem_lo_in, rem_hi_in;

      assign diff_lo   = {1'b0, rem_lo_ff[k]} - ((NW+1)'(dv_d_ff[k]) << SH);
      assign diff_hi   = {1'b0, rem_hi_ff[k]} - ((NW+1)'(dv_d_ff[k]) << SH);
      assign rem_lo_in = diff_lo[NW] ? rem_lo_ff[k] : diff_lo[NW-1:0];
      assign rem_hi_in = diff_hi[NW] ? rem_hi_ff[k] : diff_hi[NW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         rem_lo_ff[k+1]    <= rem_lo_in;
         rem_hi_ff[k+1]    <= rem_hi_in;
         quo_lo_ff[k+1]    <= {quo_lo_ff[k][CW-2:0], ~diff_lo[NW]};
         quo_hi_ff[k+1]    <= {quo_hi_ff[k][CW-2:0], ~diff_hi[NW]};
         dv_d_ff[k+1]      <= dv_d_ff[k];
         dv_neg_lo_ff[k+1] <= dv_neg_lo_ff[k];
         dv_neg_hi_ff[k+1] <= dv_neg_hi_ff[k];
         dv_empty_ff[k+1]  <= dv_empty_ff[k];
         dv_vert_ff[k+1]   <= dv_vert_ff[k];
         dv_rminy_ff[k+1]  <= dv_rminy_ff[k];
         dv_rmaxy_ff[k+1]  <= dv_rmaxy_ff[k];
         dv_y1_ff[k+1]     <= dv_y1_ff[k];
         dv_y2_ff[k+1]     <= dv_y2_ff[k];
      end
   end

   // stage f1: y at the clipped ends, vertical segments keep their endpoints
   logic signed [WW-1:0]   y1_wide, y2_wide, q_lo_wide, q_hi_wide;
   logic signed [WW-1:0]   f1_ya_in, f1_yb_in;
   logic                   f1_valid_ff, f1_empty_ff;
   logic signed [WW-1:0]   f1_ya_ff, f1_yb_ff, f1_rminy_ff, f1_rmaxy_ff;

   assign y1_wide   = WW'(dv_y1_ff[CW]);
   assign y2_wide   = WW'(dv_y2_ff[CW]);
   assign q_lo_wide = WW'(quo_lo_ff[CW]);
   assign q_hi_wide = WW'(quo_hi_ff[CW]);

   always_comb begin
      if (dv_vert_ff[CW]) begin
         f1_ya_in = y1_wide;
         f1_yb_in = y2_wide;
      end else begin
         f1_ya_in = dv_neg_lo_ff[CW] ? (y1_wide - q_lo_wide) : (y1_wide + q_lo_wide);
         f1_yb_in = dv_neg_hi_ff[CW] ? (y1_wide - q_hi_wide) : (y1_wide + q_hi_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= dv_valid_ff[CW];
      end
      f1_ya_ff    <= f1_ya_in;
      f1_yb_ff    <= f1_yb_in;
      f1_empty_ff <= dv_empty_ff[CW];
      f1_rminy_ff <= dv_rminy_ff[CW];
      f1_rmaxy_ff <= dv_rmaxy_ff[CW];
   end

   // stage f2: y range against the rectangle, edges included
   logic rsp_hit_in;
   logic rsp_valid_ff, rsp_hit_ff;

   assign rsp_hit_in = !f1_empty_ff
                    && ((f1_ya_ff <= f1_rmaxy_ff) || (f1_yb_ff <= f1_rmaxy_ff))
                    && ((f1_ya_ff >= f1_rminy_ff) || (f1_yb_ff >= f1_rminy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f1_valid_ff;
      end
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // every accepted transaction comes out after the fixed latency
   a_latency_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted transaction did not produce a result");

   // no result without a transaction accepted the fixed latency before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching transaction");

   // an empty x span always ends as a miss
   a_empty_miss: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_empty_ff) |-> ##(LATENCY-3) (rsp_valid && !rsp_hit))
      else $error("empty x span reported as a hit");

   // divider remainders end below the divisor for sloped segments
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (dv_valid_ff[CW] && !dv_vert_ff[CW] && !dv_empty_ff[CW])
         |-> ((rem_lo_ff[CW] < NW'(dv_d_ff[CW])) && (rem_hi_ff[CW] < NW'(dv_d_ff[CW]))))
      else $error("divider remainder out of range");

endmodule
